// ----- hdl/ccf_pkg.sv -----
// ccf_pkg: widths, payload structs and sideband types of the circumcircle unit
// no dependencies; imported by every module of the unit
package ccf_pkg;

  // coordinate and derived datapath widths
  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;          // point differences
  localparam int SqW    = 2 * CoordW;          // squares and norms
  localparam int AbW    = SqW + 1;             // norm differences
  localparam int LoW    = DiffW;               // low slice of a norm difference
  localparam int HiW    = AbW - LoW;           // high slice of a norm difference
  localparam int PlW    = LoW + 1 + DiffW;     // low partial product
  localparam int PhW    = HiW + DiffW;         // high partial product
  localparam int TermW  = AbW + DiffW;         // full numerator term
  localparam int NumW   = TermW + 1;           // numerator, also its magnitude
  localparam int PdW    = 2 * DiffW;           // determinant product
  localparam int DetW   = PdW + 1;             // determinant
  localparam int DenW   = DetW + 1;            // denominator, also its magnitude
  localparam int QW     = 32;                  // quotient and output width
  localparam int CmpW   = DenW + QW;           // overflow compare
  localparam int EW     = QW + 1;              // centre minus first point
  localparam int ESqW   = 2 * EW;              // squared offset
  localparam int DistW  = ESqW + 1;            // squared distance
  localparam int RootW  = QW;                  // radius
  localparam int RadInW = 2 * RootW;           // root operand
  localparam int RemW   = RootW + 2;           // root remainder

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic signed [QW-1:0] centre_x;
    logic signed [QW-1:0] centre_y;
    logic [RootW-1:0]     radius;
    logic                 clipped;
  } out_t;

  // per-item status that rides beside the divider
  typedef struct packed {
    logic                     found;
    logic                     neg_x;
    logic                     neg_y;
    logic                     ovf_x;
    logic                     ovf_y;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
  } front_t;

  // per-item status that rides beside the root unit
  typedef struct packed {
    logic                 found;
    logic                 clip;
    logic                 rclip;
    logic signed [QW-1:0] ox;
    logic signed [QW-1:0] oy;
  } post_t;

endpackage

// ----- hdl/ccf_front.sv -----
// ccf_front: seven-stage front end, norms, determinant, numerators, overflow
// depends on ccf_pkg
module ccf_front import ccf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  in_t               pts_i,
  output logic              valid_o,
  output front_t            sb_o,
  output logic [NumW-1:0]   num_x_o,
  output logic [NumW-1:0]   num_y_o,
  output logic [DenW-1:0]   den_o
);

  // stage 1: differences and squares
  logic signed [DiffW-1:0] dxab_d, dyab_d, dxbc_d, dybc_d;
  logic signed [DiffW-1:0] dxab1_q, dyab1_q, dxbc1_q, dybc1_q;
  logic signed [SqW-1:0]   sax_d, say_d, sbx_d, sby_d, scx_d, scy_d;
  logic [SqW-1:0]          sax1_q, say1_q, sbx1_q, sby1_q, scx1_q, scy1_q;
  logic signed [CoordW-1:0] ax1_q, ay1_q;
  logic                    v1_q;

  always_comb begin
    dxab_d = DiffW'(pts_i.a_x) - DiffW'(pts_i.b_x);
    dyab_d = DiffW'(pts_i.a_y) - DiffW'(pts_i.b_y);
    dxbc_d = DiffW'(pts_i.b_x) - DiffW'(pts_i.c_x);
    dybc_d = DiffW'(pts_i.b_y) - DiffW'(pts_i.c_y);
    sax_d  = SqW'(pts_i.a_x) * SqW'(pts_i.a_x);
    say_d  = SqW'(pts_i.a_y) * SqW'(pts_i.a_y);
    sbx_d  = SqW'(pts_i.b_x) * SqW'(pts_i.b_x);
    sby_d  = SqW'(pts_i.b_y) * SqW'(pts_i.b_y);
    scx_d  = SqW'(pts_i.c_x) * SqW'(pts_i.c_x);
    scy_d  = SqW'(pts_i.c_y) * SqW'(pts_i.c_y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxab1_q <= dxab_d;
      dyab1_q <= dyab_d;
      dxbc1_q <= dxbc_d;
      dybc1_q <= dybc_d;
      sax1_q  <= $unsigned(sax_d);
      say1_q  <= $unsigned(say_d);
      sbx1_q  <= $unsigned(sbx_d);
      sby1_q  <= $unsigned(sby_d);
      scx1_q  <= $unsigned(scx_d);
      scy1_q  <= $unsigned(scy_d);
      ax1_q   <= pts_i.a_x;
      ay1_q   <= pts_i.a_y;
    end
  end

  // stage 2: norm differences and determinant products
  logic [SqW-1:0]          na_d, nb_d, nc_d;
  logic signed [AbW-1:0]   ab_d, bc_d, ab2_q, bc2_q;
  logic signed [PdW-1:0]   p1_d, p2_d, p12_q, p22_q;
  logic signed [DiffW-1:0] dxab2_q, dyab2_q, dxbc2_q, dybc2_q;
  logic signed [CoordW-1:0] ax2_q, ay2_q;
  logic                    v2_q;

  always_comb begin
    na_d = sax1_q + say1_q;
    nb_d = sbx1_q + sby1_q;
    nc_d = scx1_q + scy1_q;
    ab_d = $signed({1'b0, na_d}) - $signed({1'b0, nb_d});
    bc_d = $signed({1'b0, nb_d}) - $signed({1'b0, nc_d});
    p1_d = PdW'(dxab1_q) * PdW'(dybc1_q);
    p2_d = PdW'(dxbc1_q) * PdW'(dyab1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab2_q   <= ab_d;
      bc2_q   <= bc_d;
      p12_q   <= p1_d;
      p22_q   <= p2_d;
      dxab2_q <= dxab1_q;
      dyab2_q <= dyab1_q;
      dxbc2_q <= dxbc1_q;
      dybc2_q <= dybc1_q;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
    end
  end

  // stage 3: determinant and split partial products of the numerators
  logic signed [DetW-1:0]  det_d, det3_q;
  logic signed [HiW-1:0]   abh, bch;
  logic signed [LoW:0]     abl, bcl;
  logic signed [PhW-1:0]   h1_d, h2_d, h3_d, h4_d, h13_q, h23_q, h33_q, h43_q;
  logic signed [PlW-1:0]   l1_d, l2_d, l3_d, l4_d, l13_q, l23_q, l33_q, l43_q;
  logic signed [CoordW-1:0] ax3_q, ay3_q;
  logic                    v3_q;

  always_comb begin
    det_d = DetW'(p12_q) - DetW'(p22_q);
    abh   = ab2_q[AbW-1:LoW];
    bch   = bc2_q[AbW-1:LoW];
    abl   = $signed({1'b0, ab2_q[LoW-1:0]});
    bcl   = $signed({1'b0, bc2_q[LoW-1:0]});
    h1_d  = PhW'(abh) * PhW'(dybc2_q);
    l1_d  = PlW'(abl) * PlW'(dybc2_q);
    h2_d  = PhW'(bch) * PhW'(dyab2_q);
    l2_d  = PlW'(bcl) * PlW'(dyab2_q);
    h3_d  = PhW'(bch) * PhW'(dxab2_q);
    l3_d  = PlW'(bcl) * PlW'(dxab2_q);
    h4_d  = PhW'(abh) * PhW'(dxbc2_q);
    l4_d  = PlW'(abl) * PlW'(dxbc2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det3_q <= det_d;
      h13_q  <= h1_d;
      h23_q  <= h2_d;
      h33_q  <= h3_d;
      h43_q  <= h4_d;
      l13_q  <= l1_d;
      l23_q  <= l2_d;
      l33_q  <= l3_d;
      l43_q  <= l4_d;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
    end
  end

  // stage 4: recombine partial products, denominator, collinear check
  logic signed [TermW-1:0] t1_d, t2_d, t3_d, t4_d, t14_q, t24_q, t34_q, t44_q;
  logic signed [DenW-1:0]  den4_q;
  logic                    found4_q;
  logic signed [CoordW-1:0] ax4_q, ay4_q;
  logic                    v4_q;

  always_comb begin
    t1_d = (TermW'(h13_q) <<< LoW) + TermW'(l13_q);
    t2_d = (TermW'(h23_q) <<< LoW) + TermW'(l23_q);
    t3_d = (TermW'(h33_q) <<< LoW) + TermW'(l33_q);
    t4_d = (TermW'(h43_q) <<< LoW) + TermW'(l43_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t14_q    <= t1_d;
      t24_q    <= t2_d;
      t34_q    <= t3_d;
      t44_q    <= t4_d;
      den4_q   <= {det3_q, 1'b0};
      found4_q <= (det3_q != '0);
      ax4_q    <= ax3_q;
      ay4_q    <= ay3_q;
    end
  end

  // stage 5: numerators
  logic signed [NumW-1:0]  numx5_q, numy5_q;
  logic signed [DenW-1:0]  den5_q;
  logic                    found5_q;
  logic signed [CoordW-1:0] ax5_q, ay5_q;
  logic                    v5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx5_q  <= NumW'(t14_q) - NumW'(t24_q);
      numy5_q  <= NumW'(t34_q) - NumW'(t44_q);
      den5_q   <= den4_q;
      found5_q <= found4_q;
      ax5_q    <= ax4_q;
      ay5_q    <= ay4_q;
    end
  end

  // stage 6: magnitudes and quotient signs
  logic [NumW-1:0]         mx_d, my_d, mx6_q, my6_q;
  logic [DenW-1:0]         md_d, md6_q;
  logic                    negx6_q, negy6_q, found6_q;
  logic signed [CoordW-1:0] ax6_q, ay6_q;
  logic                    v6_q;

  always_comb begin
    mx_d = numx5_q[NumW-1] ? $unsigned(-numx5_q) : $unsigned(numx5_q);
    my_d = numy5_q[NumW-1] ? $unsigned(-numy5_q) : $unsigned(numy5_q);
    md_d = den5_q[DenW-1] ? $unsigned(-den5_q) : $unsigned(den5_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx6_q    <= mx_d;
      my6_q    <= my_d;
      md6_q    <= md_d;
      negx6_q  <= numx5_q[NumW-1] ^ den5_q[DenW-1];
      negy6_q  <= numy5_q[NumW-1] ^ den5_q[DenW-1];
      found6_q <= found5_q;
      ax6_q    <= ax5_q;
      ay6_q    <= ay5_q;
    end
  end

  // stage 7: quotient overflow, |num| >= (limit + 1) * |den|
  logic [CmpW-1:0] limx_d, limy_d;
  front_t          sb_d, sb7_q;
  logic [NumW-1:0] mx7_q, my7_q;
  logic [DenW-1:0] md7_q;
  logic            v7_q;

  always_comb begin
    limx_d = (CmpW'(md6_q) << (QW - 1)) + (negx6_q ? CmpW'(md6_q) : '0);
    limy_d = (CmpW'(md6_q) << (QW - 1)) + (negy6_q ? CmpW'(md6_q) : '0);
    sb_d.found = found6_q;
    sb_d.neg_x = negx6_q;
    sb_d.neg_y = negy6_q;
    sb_d.ovf_x = CmpW'(mx6_q) >= limx_d;
    sb_d.ovf_y = CmpW'(my6_q) >= limy_d;
    sb_d.a_x   = ax6_q;
    sb_d.a_y   = ay6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb7_q <= sb_d;
      mx7_q <= mx6_q;
      my7_q <= my6_q;
      md7_q <= md6_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  assign valid_o = v7_q;
  assign sb_o    = sb7_q;
  assign num_x_o = mx7_q;
  assign num_y_o = my7_q;
  assign den_o   = md7_q;

endmodule

// ----- hdl/ccf_div.sv -----
// ccf_div: two-lane restoring divider, one quotient bit per pipeline stage
// depends on ccf_pkg
module ccf_div import ccf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_x_i,
  input  logic [NumW-1:0] num_y_i,
  input  logic [DenW-1:0] den_i,
  output logic            valid_o,
  output logic [QW-1:0]   quo_x_o,
  output logic [QW-1:0]   quo_y_o
);

  logic [DenW-1:0] rem_q [QW][2];
  logic [QW-1:0]   low_q [QW][2];
  logic [QW-1:0]   quo_q [QW][2];
  logic [DenW-1:0] den_q [QW];
  logic            v_q   [QW];

  // stage k resolves quotient bit QW-1-k
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DenW-1:0] den_in;
    logic            v_in;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign v_in   = v_q[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DenW-1:0] rem_in;
      logic [QW-1:0]   low_in, quo_in;
      logic [DenW:0]   sh;
      logic            ge;
      logic [DenW:0]   diff;

      if (k == 0) begin : g_first
        logic [NumW-1:0] num;
        assign num    = (l == 0) ? num_x_i : num_y_i;
        assign rem_in = DenW'(num >> QW);
        assign low_in = num[QW-1:0];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign low_in = low_q[k-1][l];
        assign quo_in = quo_q[k-1][l];
      end

      // trial subtract
      always_comb begin
        sh   = {rem_in, low_in[QW-1]};
        ge   = sh >= {1'b0, den_in};
        diff = sh - {1'b0, den_in};
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? diff[DenW-1:0] : sh[DenW-1:0];
          low_q[k][l] <= {low_in[QW-2:0], 1'b0};
          quo_q[k][l] <= {quo_in[QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_x_o = quo_q[QW-1][0];
  assign quo_y_o = quo_q[QW-1][1];

endmodule

// ----- hdl/ccf_sqrt.sv -----
// ccf_sqrt: digit-by-digit floor square root, one root bit per pipeline stage
// depends on ccf_pkg
module ccf_sqrt import ccf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RadInW-1:0] val_i,
  output logic              valid_o,
  output logic [RootW-1:0]  root_o
);

  logic [RemW-1:0]   rem_q  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic [RadInW-1:0] val_q  [RootW];
  logic              v_q    [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0]   rem_in;
    logic [RootW-1:0]  root_in;
    logic [RadInW-1:0] val_in;
    logic              v_in;
    logic [RemW+1:0]   r2, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      r2    = {rem_in, val_in[RadInW-1 -: 2]};
      trial = (RemW+2)'({root_in, 2'b01});
      ge    = r2 >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? RemW'(r2 - trial) : RemW'(r2);
        root_q[k] <= {root_in[RootW-2:0], ge};
        val_q[k]  <= {val_in[RadInW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = root_q[RootW-1];

endmodule

// ----- hdl/circumcircle_from_three_points_unit.sv -----
// circumcircle_from_three_points_unit: top level, circle through three points
// depends on ccf_pkg, ccf_front, ccf_div, ccf_sqrt
//
//  channel  | ports                              | payload
//  ---------+------------------------------------+--------------------------
//  in       | in_valid_i, in_stall_o, in_i       | in_t, three Q15.8 points
//  out      | out_valid_o, out_stall_i, out_o    | out_t, centre, radius, flags
//
// one item enters per cycle unless the output stalls; the pipeline has 7 front
// stages, 32 divider stages (one quotient bit each), 4 centre and distance stages,
// 32 root stages (one root bit each) and the output register
// reset clears only the valid bits; the data registers are not reset
// a stalled output item holds the whole pipeline, in_stall_o follows it
module circumcircle_from_three_points_unit import ccf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic en;
  logic out_valid_q;
  out_t out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // front end
  logic            fv;
  front_t          fsb;
  logic [NumW-1:0] fnx, fny;
  logic [DenW-1:0] fden;

  ccf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pts_i   (in_i),
    .valid_o (fv),
    .sb_o    (fsb),
    .num_x_o (fnx),
    .num_y_o (fny),
    .den_o   (fden)
  );

  // divider and its sideband
  logic          dv;
  logic [QW-1:0] qx, qy;
  front_t        dsb_q [QW];

  ccf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .num_x_i (fnx),
    .num_y_i (fny),
    .den_i   (fden),
    .valid_o (dv),
    .quo_x_o (qx),
    .quo_y_o (qy)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsb_q[0] <= fsb;
      for (int i = 1; i < QW; i++) begin
        dsb_q[i] <= dsb_q[i-1];
      end
    end
  end

  // p1: saturate and sign the centre
  front_t                   sb;
  logic [QW-1:0]            magx, magy;
  logic signed [QW:0]       sx_d, sy_d;
  logic signed [QW-1:0]     ox1_q, oy1_q;
  logic                     found1_q, clip1_q, v1_q;
  logic signed [CoordW-1:0] ax1_q, ay1_q;

  always_comb begin
    sb   = dsb_q[QW-1];
    magx = sb.ovf_x ? (sb.neg_x ? (QW'(1) << (QW - 1)) : {1'b0, {(QW-1){1'b1}}}) : qx;
    magy = sb.ovf_y ? (sb.neg_y ? (QW'(1) << (QW - 1)) : {1'b0, {(QW-1){1'b1}}}) : qy;
    sx_d = sb.neg_x ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
    sy_d = sb.neg_y ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox1_q    <= sx_d[QW-1:0];
      oy1_q    <= sy_d[QW-1:0];
      found1_q <= sb.found;
      clip1_q  <= sb.ovf_x | sb.ovf_y;
      ax1_q    <= sb.a_x;
      ay1_q    <= sb.a_y;
    end
  end

  // p2: offset from the first point
  logic signed [EW-1:0] ex2_q, ey2_q;
  logic signed [QW-1:0] ox2_q, oy2_q;
  logic                 found2_q, clip2_q, v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex2_q    <= EW'(ox1_q) - EW'(ax1_q);
      ey2_q    <= EW'(oy1_q) - EW'(ay1_q);
      ox2_q    <= ox1_q;
      oy2_q    <= oy1_q;
      found2_q <= found1_q;
      clip2_q  <= clip1_q;
    end
  end

  // p3: squared offsets
  logic signed [ESqW-1:0] exx3_q, eyy3_q;
  logic signed [QW-1:0]   ox3_q, oy3_q;
  logic                   found3_q, clip3_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      exx3_q   <= ESqW'(ex2_q) * ESqW'(ex2_q);
      eyy3_q   <= ESqW'(ey2_q) * ESqW'(ey2_q);
      ox3_q    <= ox2_q;
      oy3_q    <= oy2_q;
      found3_q <= found2_q;
      clip3_q  <= clip2_q;
    end
  end

  // p4: squared distance and radius range check
  logic [DistW-1:0]  dist_d;
  logic [RadInW-1:0] dist4_q;
  post_t             psb4_q;
  logic              v4_q;

  assign dist_d = DistW'($unsigned(exx3_q)) + DistW'($unsigned(eyy3_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist4_q      <= dist_d[RadInW-1:0];
      psb4_q.found <= found3_q;
      psb4_q.clip  <= clip3_q;
      psb4_q.rclip <= (dist_d[DistW-1:RadInW] != '0);
      psb4_q.ox    <= ox3_q;
      psb4_q.oy    <= oy3_q;
    end
  end

  // root unit and its sideband
  logic             rv;
  logic [RootW-1:0] root;
  post_t            rsb_q [RootW];
  post_t            rsb;

  ccf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .val_i   (dist4_q),
    .valid_o (rv),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsb_q[0] <= psb4_q;
      for (int i = 1; i < RootW; i++) begin
        rsb_q[i] <= rsb_q[i-1];
      end
    end
  end

  // output register
  out_t out_d;

  always_comb begin
    rsb = rsb_q[RootW-1];
    if (rsb.found) begin
      out_d.found    = 1'b1;
      out_d.centre_x = rsb.ox;
      out_d.centre_y = rsb.oy;
      out_d.radius   = rsb.rclip ? '1 : root;
      out_d.clipped  = rsb.clip | rsb.rclip;
    end else begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= dv;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= rv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // collinear items carry an all-zero result
  a_collinear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.found |-> out_o.centre_x == '0 && out_o.centre_y == '0
      && out_o.radius == '0 && !out_o.clipped)
    else $error("collinear item with nonzero result");

  // backpressure only comes from a held output item
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a stalled pipeline keeps its items in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v4_q) && $stable(v1_q) && $stable(dist4_q))
    else $error("pipeline moved during a stall");

  // radius saturation always raises the clipped flag
  a_radius_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && rv && rsb.found && rsb.rclip |=> out_valid_o && out_o.clipped
      && out_o.radius == '1)
    else $error("radius saturated without clipped flag");

endmodule
